FILE: src/lidar_polar_to_vehicle_xyz_core_macros.svh
// Assertion macros shared by the lidar point transform checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LIDAR_POLAR_TO_VEHICLE_XYZ_CORE_MACROS_SVH
`define LIDAR_POLAR_TO_VEHICLE_XYZ_CORE_MACROS_SVH

// same-cycle implication, off while in reset
`define LP2V_CHK_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lp2v check failed");

// next-cycle implication, off while in reset
`define LP2V_CHK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lp2v check failed");

// next-cycle implication, also checked through reset
`define LP2V_CHK_NEXT_RST(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lp2v check failed");

`endif

FILE: src/lp2v_pkg.sv
// Package for the lidar polar to vehicle point transform.
// Types, constants and register codes used by all lp2v modules but the checker.
`default_nettype none

package lp2v_pkg;

  localparam int HORIZONTAL_POINTS_DEF = 1024;
  localparam int VERTICAL_POINTS_DEF   = 64;

  // configuration port
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  // angle and fixed point
  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam int          Q15_SHIFT    = 15;
  localparam int          SIN_SHIFT    = 14;
  localparam logic [14:0] SIN_T_ONE    = 15'd16384;
  localparam logic [11:0] SIN_C2       = 12'd2320;
  localparam logic [14:0] SIN_C1       = 15'd21024;
  localparam logic [15:0] SIN_C0       = 16'd51472;
  localparam logic [16:0] SIN_MAX      = 17'd32767;

  // output saturation
  localparam int OUT_MAX  = 2097151;
  localparam int OUT_MIN  = -2097152;
  localparam int ACC_SHIFT = 30;

  // datapath widths
  localparam int PT_W   = 37;  // sensor point, Q15 mm
  localparam int M_W    = 18;  // rotation entry, Q15
  localparam int PROD_W = PT_W + M_W;
  localparam int ACC_W  = PROD_W + 2;

  typedef logic signed [15:0]     q15_t;
  typedef logic signed [M_W-1:0]  mval_t;
  typedef logic signed [PT_W-1:0] pt_t;

  typedef enum logic [2:0] {
    REG_AZ_START = 3'd0,
    REG_AZ_STEP  = 3'd1,
    REG_EL_START = 3'd2,
    REG_EL_STEP  = 3'd3,
    REG_YAW      = 3'd4,
    REG_PITCH    = 3'd5,
    REG_ROLL     = 3'd6,
    REG_OFFSET   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] az_start;
    logic [14:0] az_step;
    logic [15:0] el_start;
    logic [14:0] el_step;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
    logic [47:0] offset;
  } cfg_t;

  typedef struct packed {
    mval_t m00;
    mval_t m01;
    mval_t m02;
    mval_t m10;
    mval_t m11;
    mval_t m12;
    mval_t m20;
    mval_t m21;
    mval_t m22;
  } mat_t;

endpackage

`default_nettype wire

FILE: src/lidar_polar_to_vehicle_xyz_core.sv
// Lidar return to vehicle-frame point, top level.
// Uses lp2v_pkg, lp2v_cfg, lp2v_sin, lp2v_mount and lp2v_rotate.
//
// Usage:
//   in_*  : one lidar return per item; in_tdata holds range, column and row,
//           in_tuser the no-return flag. Accepted when in_tvalid && in_tready.
//   out_* : one vehicle-frame point (x, y, z mm, saturated) per input item,
//           in input order. Taken when out_tvalid && out_tready.
//   cfg_* : APB-style register port, 64-bit data, register i at 8*i.
// Throughput: one item per clock while in_tready is high. Items pass the
//   S0 angle stage, four sine stages, two sensor product stages, three
//   rotation stages and the output register (the S0 angle stage loads at
//   the accepting edge).
// Mount angle writes reach the rotation matrix through the mount stages,
//   before any item accepted after the write reaches the rotation stage.
// Reset (rst_n low, synchronous) empties the pipeline and output buffer and
//   restores register defaults (steps 64, all else 0).
// Stall: an output register plus one skid entry; in_tready is registered and
//   drops only while the skid entry is full, which freezes the whole pipeline.
`default_nettype none

module lidar_polar_to_vehicle_xyz_core #(
  parameter int HORIZONTAL_POINTS = lp2v_pkg::HORIZONTAL_POINTS_DEF,
  parameter int VERTICAL_POINTS   = lp2v_pkg::VERTICAL_POINTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [39:0]                 in_tdata,   // range_mm[19:0], column_index[29:20],
                                                       // row_index[35:30], zero pad
  input  wire logic                        in_tuser,   // no_return
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [71:0]                      out_tdata,  // x_mm[21:0], y_mm[43:22],
                                                       // z_mm[65:44], zero pad
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [lp2v_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [lp2v_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [lp2v_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  lp2v_pkg::cfg_t cfg;
  lp2v_pkg::mat_t mat;
  logic           en;

  assign cfg_pready = 1'b1;

  lp2v_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .cfg(cfg)
  );

  lp2v_mount u_mount (
    .clk(clk), .yaw(cfg.yaw), .pitch(cfg.pitch), .roll(cfg.roll), .mat(mat)
  );

  // stage S0: clamp indices, form angles
  logic [9:0]  col_c;
  logic [5:0]  row_c;
  logic [24:0] az_prod;
  logic [20:0] el_prod;
  logic [19:0] r_in;
  logic [15:0] az_nxt, el_nxt;

  always_comb begin
    col_c = in_tdata[29:20];
    row_c = in_tdata[35:30];
    if (int'(col_c) >= HORIZONTAL_POINTS) begin
      col_c = 10'(HORIZONTAL_POINTS - 1);
    end
    if (int'(row_c) >= VERTICAL_POINTS) begin
      row_c = 6'(VERTICAL_POINTS - 1);
    end
    r_in    = in_tuser ? 20'd0 : in_tdata[19:0];
    az_prod = 25'(col_c) * 25'(cfg.az_step);
    el_prod = 21'(row_c) * 21'(cfg.el_step);
    az_nxt  = cfg.az_start + az_prod[15:0];
    el_nxt  = cfg.el_start + el_prod[15:0];
  end

  logic [19:0] r_r;
  logic [15:0] az_r, el_r;
  logic [19:0] r_dly_r [4];
  logic [6:0]  vld_r;

  // sine stages
  lp2v_pkg::q15_t ca, sa, ce, se;

  lp2v_sin u_ca (.clk(clk), .en(en), .angle(az_r + lp2v_pkg::QUARTER_TURN), .sin_out(ca));
  lp2v_sin u_sa (.clk(clk), .en(en), .angle(az_r),                          .sin_out(sa));
  lp2v_sin u_ce (.clk(clk), .en(en), .angle(el_r + lp2v_pkg::QUARTER_TURN), .sin_out(ce));
  lp2v_sin u_se (.clk(clk), .en(en), .angle(el_r),                          .sin_out(se));

  // stage P1: range times azimuth terms and elevation sine; P2: times elevation cosine
  lp2v_pkg::pt_t  ra_r, rs_r, pz1_r, px_r, py_r, pz_r;
  lp2v_pkg::q15_t ce_r;
  logic signed [lp2v_pkg::PT_W-1:0]  r_s;
  logic signed [lp2v_pkg::PT_W+15:0] px_prod, py_prod;

  always_comb begin
    r_s     = lp2v_pkg::PT_W'(signed'({1'b0, r_dly_r[3]}));
    px_prod = (lp2v_pkg::PT_W+16)'(ra_r) * (lp2v_pkg::PT_W+16)'(ce_r);
    py_prod = (lp2v_pkg::PT_W+16)'(rs_r) * (lp2v_pkg::PT_W+16)'(ce_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r        <= r_in;
      az_r       <= az_nxt;
      el_r       <= el_nxt;
      r_dly_r[0] <= r_r;
      r_dly_r[1] <= r_dly_r[0];
      r_dly_r[2] <= r_dly_r[1];
      r_dly_r[3] <= r_dly_r[2];
      ra_r       <= r_s * lp2v_pkg::PT_W'(ca);
      rs_r       <= r_s * lp2v_pkg::PT_W'(sa);
      pz1_r      <= r_s * lp2v_pkg::PT_W'(se);
      ce_r       <= ce;
      px_r       <= lp2v_pkg::PT_W'(px_prod >>> lp2v_pkg::Q15_SHIFT);
      py_r       <= lp2v_pkg::PT_W'(py_prod >>> lp2v_pkg::Q15_SHIFT);
      pz_r       <= pz1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_tvalid};
    end
  end

  // rotation and offset
  logic        rot_vld;
  logic [65:0] rot_xyz;

  lp2v_rotate u_rot (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld_r[6]),
    .px(px_r), .py(py_r), .pz(pz_r), .mat(mat), .offset(cfg.offset),
    .out_vld(rot_vld), .out_xyz(rot_xyz)
  );

  // output register with one skid entry
  logic        main_v_r, main_v_nxt, skid_v_r, skid_v_nxt;
  logic [65:0] main_d_r, main_d_nxt, skid_d_r, skid_d_nxt;
  logic        push, pop;

  assign en   = !skid_v_r;
  assign push = en && rot_vld;
  assign pop  = main_v_r && out_tready;

  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (pop) begin
      if (skid_v_r) begin
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = push;
        main_d_nxt = rot_xyz;
      end
    end else if (!main_v_r) begin
      main_v_nxt = push;
      main_d_nxt = rot_xyz;
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = rot_xyz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign in_tready  = en;
  assign out_tvalid = main_v_r;
  assign out_tdata  = {6'd0, main_d_r};

endmodule

`default_nettype wire

FILE: src/lp2v_sin.sv
// Four-stage pipelined sine of a 16-bit turn angle, Q1.15 result.
// Polynomial quarter-wave with quadrant folding; uses lp2v_pkg.
`default_nettype none

module lp2v_sin (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [15:0]   angle,
  output lp2v_pkg::q15_t     sin_out
);

  logic [14:0] a_t_r, a_x2_r;
  logic        a_neg_r;
  logic [14:0] b_q_r, b_x2_r, b_t_r;
  logic        b_neg_r;
  logic [15:0] c_s_r;
  logic [14:0] c_t_r;
  logic        c_neg_r;
  lp2v_pkg::q15_t d_out_r;

  logic [14:0] a_t_nxt, a_x2_nxt;
  logic [29:0] a_sq;
  logic [26:0] b_prod;
  logic [14:0] b_q_nxt;
  logic [29:0] c_prod;
  logic [15:0] c_s_nxt;
  logic [30:0] d_prod;
  logic [16:0] d_v;
  lp2v_pkg::q15_t d_out_nxt;

  // stage A: fold quadrant, square
  always_comb begin
    a_t_nxt = {1'b0, angle[13:0]};
    if (angle[14]) begin
      a_t_nxt = lp2v_pkg::SIN_T_ONE - {1'b0, angle[13:0]};
    end
    a_sq     = 30'(a_t_nxt) * 30'(a_t_nxt);
    a_x2_nxt = 15'(a_sq >> lp2v_pkg::SIN_SHIFT);
  end

  // stage B: q = c1 - c2*x2
  always_comb begin
    b_prod  = 27'(lp2v_pkg::SIN_C2) * 27'(a_x2_r);
    b_q_nxt = lp2v_pkg::SIN_C1 - 15'(b_prod >> lp2v_pkg::SIN_SHIFT);
  end

  // stage C: s = c0 - q*x2
  always_comb begin
    c_prod  = 30'(b_q_r) * 30'(b_x2_r);
    c_s_nxt = lp2v_pkg::SIN_C0 - 16'(c_prod >> lp2v_pkg::SIN_SHIFT);
  end

  // stage D: s*t, saturate, sign
  always_comb begin
    d_prod = 31'(c_s_r) * 31'(c_t_r);
    d_v    = 17'(d_prod >> lp2v_pkg::SIN_SHIFT);
    if (d_v > lp2v_pkg::SIN_MAX) begin
      d_v = lp2v_pkg::SIN_MAX;
    end
    d_out_nxt = c_neg_r ? -signed'(d_v[15:0]) : signed'(d_v[15:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_t_r   <= a_t_nxt;
      a_x2_r  <= a_x2_nxt;
      a_neg_r <= angle[15];
      b_q_r   <= b_q_nxt;
      b_x2_r  <= a_x2_r;
      b_t_r   <= a_t_r;
      b_neg_r <= a_neg_r;
      c_s_r   <= c_s_nxt;
      c_t_r   <= b_t_r;
      c_neg_r <= b_neg_r;
      d_out_r <= d_out_nxt;
    end
  end

  assign sin_out = d_out_r;

endmodule

`default_nettype wire

FILE: src/lp2v_cfg.sv
// APB-style configuration registers of the lidar point transform.
// Holds angles, steps and offsets as an lp2v_pkg::cfg_t.
`default_nettype none

module lp2v_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lp2v_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [lp2v_pkg::CFG_DW-1:0]   pwdata,
  output logic      [lp2v_pkg::CFG_DW-1:0]   prdata,
  output lp2v_pkg::cfg_t                     cfg
);

  lp2v_pkg::cfg_t     cfg_r, cfg_nxt;
  lp2v_pkg::reg_idx_t idx;
  logic               wr;

  assign idx = lp2v_pkg::reg_idx_t'(paddr[5:3]);
  assign wr  = psel && penable && pwrite;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        lp2v_pkg::REG_AZ_START: cfg_nxt.az_start = pwdata[15:0];
        lp2v_pkg::REG_AZ_STEP:  cfg_nxt.az_step  = pwdata[14:0];
        lp2v_pkg::REG_EL_START: cfg_nxt.el_start = pwdata[15:0];
        lp2v_pkg::REG_EL_STEP:  cfg_nxt.el_step  = pwdata[14:0];
        lp2v_pkg::REG_YAW:      cfg_nxt.yaw      = pwdata[15:0];
        lp2v_pkg::REG_PITCH:    cfg_nxt.pitch    = pwdata[15:0];
        lp2v_pkg::REG_ROLL:     cfg_nxt.roll     = pwdata[15:0];
        lp2v_pkg::REG_OFFSET:   cfg_nxt.offset   = pwdata[47:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      lp2v_pkg::REG_AZ_START: prdata = 64'(cfg_r.az_start);
      lp2v_pkg::REG_AZ_STEP:  prdata = 64'(cfg_r.az_step);
      lp2v_pkg::REG_EL_START: prdata = 64'(cfg_r.el_start);
      lp2v_pkg::REG_EL_STEP:  prdata = 64'(cfg_r.el_step);
      lp2v_pkg::REG_YAW:      prdata = 64'(cfg_r.yaw);
      lp2v_pkg::REG_PITCH:    prdata = 64'(cfg_r.pitch);
      lp2v_pkg::REG_ROLL:     prdata = 64'(cfg_r.roll);
      lp2v_pkg::REG_OFFSET:   prdata = 64'(cfg_r.offset);
      default:                prdata = '0;
    endcase
  end

  // steps reset to 64, everything else to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{az_start: '0, az_step: 15'd64, el_start: '0, el_step: 15'd64,
                 yaw: '0, pitch: '0, roll: '0, offset: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: src/lp2v_mount.sv
// Mounting rotation matrix R = Rz(yaw)*Ry(pitch)*Rx(roll) in Q15.
// Free-running: six lp2v_sin units then two product stages.
`default_nettype none

module lp2v_mount (
  input  wire logic           clk,
  input  wire logic [15:0]    yaw,
  input  wire logic [15:0]    pitch,
  input  wire logic [15:0]    roll,
  output lp2v_pkg::mat_t      mat
);

  lp2v_pkg::q15_t cy, sy, cp, sp, cr, sr;

  lp2v_sin u_cy (.clk(clk), .en(1'b1), .angle(yaw + lp2v_pkg::QUARTER_TURN),   .sin_out(cy));
  lp2v_sin u_sy (.clk(clk), .en(1'b1), .angle(yaw),                            .sin_out(sy));
  lp2v_sin u_cp (.clk(clk), .en(1'b1), .angle(pitch + lp2v_pkg::QUARTER_TURN), .sin_out(cp));
  lp2v_sin u_sp (.clk(clk), .en(1'b1), .angle(pitch),                          .sin_out(sp));
  lp2v_sin u_cr (.clk(clk), .en(1'b1), .angle(roll + lp2v_pkg::QUARTER_TURN),  .sin_out(cr));
  lp2v_sin u_sr (.clk(clk), .en(1'b1), .angle(roll),                           .sin_out(sr));

  // Q15 product with floor
  function automatic lp2v_pkg::q15_t qm(lp2v_pkg::q15_t a, lp2v_pkg::q15_t b);
    logic signed [31:0] p;
    p  = 32'(a) * 32'(b);
    qm = 16'(p >>> lp2v_pkg::Q15_SHIFT);
  endfunction

  lp2v_pkg::q15_t cysp_r, sysp_r, cy_r, sy_r, cr_r, sr_r;
  lp2v_pkg::mval_t m00_r, m10_r, m20_r, m21_r, m22_r;
  lp2v_pkg::mat_t  mat_r, mat_nxt;

  // stage M2: two-term entries; single-product entries pass through
  always_comb begin
    mat_nxt.m00 = m00_r;
    mat_nxt.m10 = m10_r;
    mat_nxt.m20 = m20_r;
    mat_nxt.m21 = m21_r;
    mat_nxt.m22 = m22_r;
    mat_nxt.m01 = 18'(qm(cysp_r, sr_r)) - 18'(qm(sy_r, cr_r));
    mat_nxt.m02 = 18'(qm(cysp_r, cr_r)) + 18'(qm(sy_r, sr_r));
    mat_nxt.m11 = 18'(qm(sysp_r, sr_r)) + 18'(qm(cy_r, cr_r));
    mat_nxt.m12 = 18'(qm(sysp_r, cr_r)) - 18'(qm(cy_r, sr_r));
  end

  always_ff @(posedge clk) begin
    // stage M1: single products
    cysp_r <= qm(cy, sp);
    sysp_r <= qm(sy, sp);
    m00_r  <= 18'(qm(cy, cp));
    m10_r  <= 18'(qm(sy, cp));
    m20_r  <= -18'(sp);
    m21_r  <= 18'(qm(cp, sr));
    m22_r  <= 18'(qm(cp, cr));
    cy_r   <= cy;
    sy_r   <= sy;
    cr_r   <= cr;
    sr_r   <= sr;
    mat_r  <= mat_nxt;
  end

  assign mat = mat_r;

endmodule

`default_nettype wire

FILE: src/lp2v_rotate.sv
// Rotation, translation and saturation of the sensor-frame point.
// Three stalling stages: products, row sums, shift/offset/clamp.
`default_nettype none

module lp2v_rotate (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire lp2v_pkg::pt_t  px,
  input  wire lp2v_pkg::pt_t  py,
  input  wire lp2v_pkg::pt_t  pz,
  input  wire lp2v_pkg::mat_t mat,
  input  wire logic [47:0]    offset,
  output logic                out_vld,
  output logic [65:0]         out_xyz
);

  localparam int PW = lp2v_pkg::PROD_W;
  localparam int AW = lp2v_pkg::ACC_W;
  localparam int VW = AW - lp2v_pkg::ACC_SHIFT + 1;

  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [AW-1:0] acc_t;

  prod_t p_r [9];
  acc_t  acc_r [3];
  logic  [65:0] xyz_r, xyz_nxt;
  logic  [2:0]  vld_r;

  function automatic prod_t mul(lp2v_pkg::mval_t m, lp2v_pkg::pt_t p);
    mul = PW'(m) * PW'(p);
  endfunction

  function automatic logic [21:0] fin(acc_t a, logic [15:0] off);
    logic signed [VW-1:0] v;
    v = VW'(a >>> lp2v_pkg::ACC_SHIFT) + VW'(signed'(off));
    if (v > VW'(lp2v_pkg::OUT_MAX)) begin
      v = VW'(lp2v_pkg::OUT_MAX);
    end else if (v < VW'(lp2v_pkg::OUT_MIN)) begin
      v = VW'(lp2v_pkg::OUT_MIN);
    end
    fin = v[21:0];
  endfunction

  // stage R3: floor, offset, clamp
  always_comb begin
    xyz_nxt[21:0]  = fin(acc_r[0], offset[15:0]);
    xyz_nxt[43:22] = fin(acc_r[1], offset[31:16]);
    xyz_nxt[65:44] = fin(acc_r[2], offset[47:32]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage R1: nine products
      p_r[0] <= mul(mat.m00, px);
      p_r[1] <= mul(mat.m01, py);
      p_r[2] <= mul(mat.m02, pz);
      p_r[3] <= mul(mat.m10, px);
      p_r[4] <= mul(mat.m11, py);
      p_r[5] <= mul(mat.m12, pz);
      p_r[6] <= mul(mat.m20, px);
      p_r[7] <= mul(mat.m21, py);
      p_r[8] <= mul(mat.m22, pz);
      // stage R2: row sums
      acc_r[0] <= AW'(p_r[0]) + AW'(p_r[1]) + AW'(p_r[2]);
      acc_r[1] <= AW'(p_r[3]) + AW'(p_r[4]) + AW'(p_r[5]);
      acc_r[2] <= AW'(p_r[6]) + AW'(p_r[7]) + AW'(p_r[8]);
      xyz_r    <= xyz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  assign out_vld = vld_r[2];
  assign out_xyz = xyz_r;

endmodule

`default_nettype wire

FILE: src/lp2v_checker.sv
// Port-level checker for the lidar point transform, bound to the top level.
// Uses the macros in lidar_polar_to_vehicle_xyz_core_macros.svh.
`default_nettype none
`include "lidar_polar_to_vehicle_xyz_core_macros.svh"

module lp2v_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata
);

  // a held result stays offered
  `LP2V_CHK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // a held result keeps its value
  `LP2V_CHK_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))

  // input backpressure only comes from a waiting result
  `LP2V_CHK_SAME(a_ready_cause, !in_tready, out_tvalid)

  // reset empties the output
  `LP2V_CHK_NEXT_RST(a_reset_empty, !rst_n, !out_tvalid)

endmodule

bind lidar_polar_to_vehicle_xyz_core lp2v_checker u_lp2v_checker (.*);

`default_nettype wire

FILE: tb/lidar_polar_to_vehicle_xyz_core_tb.sv
// Testbench for lidar_polar_to_vehicle_xyz_core: drives lidar returns and APB writes,
// predicts each vehicle-frame point in fixed point and checks every output item.
// Depends on lp2v_pkg and the core RTL only.
`timescale 1ns / 1ps

module lidar_polar_to_vehicle_xyz_core_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;   // range_mm[19:0], column_index[29:20], row_index[35:30]
  logic in_tuser = 1'b0;        // no_return
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;       // x_mm[21:0], y_mm[43:22], z_mm[65:44]
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [lp2v_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [lp2v_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [lp2v_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  lidar_polar_to_vehicle_xyz_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct packed {
    logic [21:0] z;
    logic [21:0] y;
    logic [21:0] x;
  } point_t;

  // shadow copy of the register file
  logic [15:0] az0, el0, yaw, pitch, roll;
  logic [14:0] az_d, el_d;
  logic [47:0] offs;

  point_t point_q[$];
  int errors = 0;
  int n_out = 0;
  bit sender_done = 0;

  function automatic longint fdiv(longint p, int s);
    return p >>> s;  // arithmetic shift is floor
  endfunction

  function automatic longint qm(longint a, longint b);
    return fdiv(a * b, 15);
  endfunction

  function automatic longint sin_q(logic [15:0] a);
    longint t, x2, s, v;
    t = a[13:0];
    if (a[14]) t = 16384 - t;
    x2 = (t * t) >> 14;
    s = 51472 - (((21024 - ((2320 * x2) >> 14)) * x2) >> 14);
    v = (s * t) >> 14;
    if (v > 32767) v = 32767;
    return a[15] ? -v : v;
  endfunction

  function automatic longint cos_q(logic [15:0] a);
    return sin_q(a + lp2v_pkg::QUARTER_TURN);
  endfunction

  function automatic logic [21:0] sat_coord(longint acc, logic [15:0] off);
    longint v;
    v = fdiv(acc, lp2v_pkg::ACC_SHIFT) + longint'($signed(off));
    if (v > lp2v_pkg::OUT_MAX) v = lp2v_pkg::OUT_MAX;
    if (v < lp2v_pkg::OUT_MIN) v = lp2v_pkg::OUT_MIN;
    return v[21:0];
  endfunction

  function automatic point_t vehicle_point(logic [19:0] rng, logic nr,
                                           logic [9:0] col, logic [5:0] row);
    longint r, ca, sa, ce, se, px, py, pz;
    longint cy, sy, cp, sp, cr, sr, cysp, sysp;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic [15:0] az, el;
    point_t p;
    r = nr ? 0 : rng;
    az = az0 + col * az_d;
    el = el0 + row * el_d;
    ca = cos_q(az); sa = sin_q(az); ce = cos_q(el); se = sin_q(el);
    px = qm(r * ca, ce);
    py = qm(r * sa, ce);
    pz = r * se;
    cy = cos_q(yaw); sy = sin_q(yaw);
    cp = cos_q(pitch); sp = sin_q(pitch);
    cr = cos_q(roll); sr = sin_q(roll);
    cysp = qm(cy, sp); sysp = qm(sy, sp);
    m00 = qm(cy, cp);
    m01 = qm(cysp, sr) - qm(sy, cr);
    m02 = qm(cysp, cr) + qm(sy, sr);
    m10 = qm(sy, cp);
    m11 = qm(sysp, sr) + qm(cy, cr);
    m12 = qm(sysp, cr) - qm(cy, sr);
    m20 = -sp;
    m21 = qm(cp, sr);
    m22 = qm(cp, cr);
    p.x = sat_coord(m00 * px + m01 * py + m02 * pz, offs[15:0]);
    p.y = sat_coord(m10 * px + m11 * py + m12 * pz, offs[31:16]);
    p.z = sat_coord(m20 * px + m21 * py + m22 * pz, offs[47:32]);
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [21:0] got, logic [21:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what,
             $signed(got), $signed(want));
    errors++;
  endtask

  // output side: random backpressure, compare in order
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 9) < 7) out_tready <= 1'b1;
      else if ($urandom_range(0, 19) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(5, 40)) @(negedge clk);
        out_tready <= 1'b1;
      end else out_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    point_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[65:0];
      n_out++;
      if (point_q.size() == 0) begin
        $display("unexpected output item at %0t", $realtime);
        errors++;
      end else begin
        want = point_q.pop_front();
        if (got.x !== want.x) report_mismatch("x_mm", got.x, want.x);
        if (got.y !== want.y) report_mismatch("y_mm", got.y, want.y);
        if (got.z !== want.z) report_mismatch("z_mm", got.z, want.z);
        if (out_tdata[71:66] !== '0) report_mismatch("pad", out_tdata[71:66], '0);
      end
    end
  end

  // APB write, only while idle
  task automatic reg_write(lp2v_pkg::reg_idx_t idx, logic [63:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= lp2v_pkg::CFG_AW'(8 * idx); cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      lp2v_pkg::REG_AZ_START: az0 = val[15:0];
      lp2v_pkg::REG_AZ_STEP:  az_d = val[14:0];
      lp2v_pkg::REG_EL_START: el0 = val[15:0];
      lp2v_pkg::REG_EL_STEP:  el_d = val[14:0];
      lp2v_pkg::REG_YAW:      yaw = val[15:0];
      lp2v_pkg::REG_PITCH:    pitch = val[15:0];
      lp2v_pkg::REG_ROLL:     roll = val[15:0];
      lp2v_pkg::REG_OFFSET:   offs = val[47:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (point_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // one item; expectation queued at acceptance
  task automatic send_return(logic [19:0] rng, logic nr, logic [9:0] col, logic [5:0] row,
                             bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(8, 30) : $urandom_range(1, 3))
        @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, row, col, rng};
    in_tuser <= nr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    point_q.insert(point_q.size(), vehicle_point(rng, nr, col, row));
    @(negedge clk);
  endtask

  typedef struct {
    logic [19:0] rng;
    logic nr;
    logic [9:0] col;
    logic [5:0] row;
    bit known;
    point_t want;
  } vec_t;

  vec_t directed[] = '{
    '{20'd0,       1'b0, 10'd0,    6'd0,  1'b1, '0},
    '{20'hFFFFF,   1'b1, 10'd1023, 6'd63, 1'b1, '0},
    '{20'd1000,    1'b0, 10'd0,    6'd0,  1'b0, '0},
    '{20'hFFFFF,   1'b0, 10'd0,    6'd0,  1'b0, '0},
    '{20'hFFFFF,   1'b0, 10'd1023, 6'd63, 1'b0, '0},
    '{20'd12345,   1'b0, 10'd256,  6'd32, 1'b0, '0},
    '{20'd77777,   1'b0, 10'd512,  6'd17, 1'b0, '0},
    '{20'h55555,   1'b0, 10'h2AA,  6'h2A, 1'b0, '0},
    '{20'hAAAAA,   1'b0, 10'h155,  6'h15, 1'b0, '0},
    '{20'd1,       1'b0, 10'd768,  6'd1,  1'b0, '0}
  };

  task automatic run_random(int n, int big_pct);
    for (int i = 0; i < n; i++)
      send_return($urandom_range(0, 99) < big_pct ? 20'($urandom) : 20'($urandom_range(0, 200000)),
                  $urandom_range(0, 15) == 0, 10'($urandom), 6'($urandom), 1'b1);
    in_tvalid <= 1'b0;
  endtask

  // stimulus
  initial begin
    az0 = 0; az_d = 64; el0 = 0; el_d = 64; yaw = 0; pitch = 0; roll = 0; offs = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows at reset settings
    foreach (directed[i]) begin
      send_return(directed[i].rng, directed[i].nr, directed[i].col, directed[i].row, 1'b0);
      if (directed[i].known) point_q[$] = directed[i].want;
    end
    in_tvalid <= 1'b0;
    drain();

    // extremes: offsets saturate with large range, steps and angles at limits
    reg_write(lp2v_pkg::REG_OFFSET, 64'h7FFF_8000_7FFF);
    reg_write(lp2v_pkg::REG_AZ_STEP, 64'h7FFF);
    reg_write(lp2v_pkg::REG_EL_STEP, 64'h7FFF);
    reg_write(lp2v_pkg::REG_AZ_START, 64'h8000);
    reg_write(lp2v_pkg::REG_EL_START, 64'h7FFF);
    reg_write(lp2v_pkg::REG_YAW, 64'h8000);
    reg_write(lp2v_pkg::REG_PITCH, 64'h7FFF);
    reg_write(lp2v_pkg::REG_ROLL, 64'hFFFF);
    send_return(20'd5, 1'b1, 10'd3, 6'd3, 1'b0);
    point_q[$] = '{z: 22'sd32767, y: -22'sd32768, x: 22'sd32767};
    send_return(20'hFFFFF, 1'b0, 10'd1023, 6'd63, 1'b0);
    send_return(20'hFFFFF, 1'b0, 10'd1, 6'd0, 1'b0);
    run_random(200, 50);
    drain();

    // several random settings; the sender waits for all results between them
    for (int ph = 0; ph < 5; ph++) begin
      reg_write(lp2v_pkg::REG_AZ_START, 64'($urandom));
      reg_write(lp2v_pkg::REG_AZ_STEP, ph == 0 ? 64'd0 : 64'($urandom_range(0, 32767)));
      reg_write(lp2v_pkg::REG_EL_START, 64'($urandom));
      reg_write(lp2v_pkg::REG_EL_STEP, ph == 0 ? 64'd0 : 64'($urandom_range(0, 32767)));
      reg_write(lp2v_pkg::REG_YAW, 64'($urandom));
      reg_write(lp2v_pkg::REG_PITCH, 64'($urandom));
      reg_write(lp2v_pkg::REG_ROLL, 64'($urandom));
      reg_write(lp2v_pkg::REG_OFFSET, {$urandom, $urandom});
      run_random(220, 25);
      drain();
    end
    sender_done = 1;
  end

  // end of run
  initial begin
    wait (sender_done);
    if (errors == 0 && point_q.size() == 0)
      $display("lidar_polar_to_vehicle_xyz_core regression: pass");
    else
      $display("lidar_polar_to_vehicle_xyz_core regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("lidar_polar_to_vehicle_xyz_core regression: fail");
    $finish;
  end

endmodule
